// ===== src/sfe_pkg.sv =====
// Shared types, constants and the CRC-16/MODBUS byte update for the frame encoder.
package sfe_pkg;

  localparam logic [7:0]  FLAG_BYTE  = 8'h7E;
  localparam logic [7:0]  STUFF_BYTE = 8'h00;
  localparam logic [7:0]  CR_BYTE    = 8'h0D;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;

  // One accepted body beat, classified by the front end
  typedef struct packed {
    logic [7:0]  body;   // body byte as received
    logic        start;  // open a frame with a start byte first
    logic        stuff;  // body byte is a flag, follow with a stuffing byte
    logic        last;   // append the trailer
    logic [15:0] crc;    // CRC after this byte and its stuffing byte
  } desc_t;

  // Reflected CRC-16 update over one byte, LSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== src/stx_frame_encoder_crc16.sv =====
// Top level of the byte-stuffed frame encoder with CRC-16/MODBUS.
//
//   channel | dir | tdata            | tlast     | tuser
//   in_     | in  | [7:0] body_byte  | body_last | -
//   out_    | out | [7:0] wire_byte  | run_end   | [0] frame_end
//
// A body beat enters the front end and lands in the descriptor queue; the sequencer emits
// one wire byte per cycle into the output register while the output is not stalled and the
// queue is not empty, so a plain body byte yields one wire byte and an N-byte beat yields N.
// Input is refused only while the queue (FIFO_DEPTH descriptors) is full.
// Reset (rst_n low, synchronous) empties the queue and reopens the CRC at 0xFFFF.
// A stalled output holds its beat; the front keeps filling the queue meanwhile.
module stx_frame_encoder_crc16
  import sfe_pkg::*;
#(
  parameter int FIFO_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] body_byte
  input  logic       in_tlast,   // body_last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] wire_byte
  output logic       out_tlast,  // run_end
  output logic       out_tuser   // [0] frame_end
);

  logic  q_push, q_pop, q_full, q_empty;
  desc_t q_wdata, q_rdata;

  sfe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  sfe_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  sfe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== src/sfe_front.sv =====
// Front end: accepts body beats, runs the CRC and frame state, pushes descriptors.
module sfe_front
  import sfe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] body_byte
  input  logic       in_tlast,   // body_last
  input  logic       q_full,
  output logic       q_push,
  output desc_t      q_data
);

  logic [15:0] crc_r, crc_nxt;
  logic        in_frame_r, in_frame_nxt;
  logic [15:0] crc_body;
  logic        is_flag;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;

  // CRC covers the body byte and, for a flag byte, its stuffing byte
  always_comb begin
    is_flag  = (in_tdata == FLAG_BYTE);
    crc_body = crc_byte(crc_r, in_tdata);
    q_data.body  = in_tdata;
    q_data.start = !in_frame_r;
    q_data.stuff = is_flag;
    q_data.last  = in_tlast;
    q_data.crc   = is_flag ? crc_byte(crc_body, STUFF_BYTE) : crc_body;
    crc_nxt      = crc_r;
    in_frame_nxt = in_frame_r;
    if (q_push) begin
      crc_nxt      = in_tlast ? CRC_INIT : q_data.crc;
      in_frame_nxt = !in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r      <= CRC_INIT;
      in_frame_r <= 1'b0;
    end else begin
      crc_r      <= crc_nxt;
      in_frame_r <= in_frame_nxt;
    end
  end

endmodule

// ===== src/sfe_fifo.sv =====
// Small descriptor queue between the front end and the byte sequencer.
module sfe_fifo
  import sfe_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_data,
  output logic  full,
  input  logic  pop,
  output desc_t pop_data,
  output logic  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  desc_t         mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full     = (count_r == DEPTH_C);
  assign empty    = (count_r == '0);
  assign pop_data = mem[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop)      count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

endmodule

// ===== src/sfe_back.sv =====
// Back end: expands each descriptor into wire bytes through a registered output.
module sfe_back
  import sfe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  desc_t      q_data,
  output logic       q_pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] wire_byte
  output logic       out_tlast,   // run_end
  output logic       out_tuser    // [0] frame_end
);

  typedef enum logic [3:0] {
    P_NEW, P_START, P_BODY, P_BSTUFF, P_CRCH, P_CRCHS,
    P_CRCL, P_CRCLS, P_FLAG, P_CR, P_DONE
  } phase_t;

  phase_t     phase_r, phase_nxt;
  phase_t     cur, nxt;
  logic       valid_r;
  logic [7:0] data_r;
  logic       last_r;
  logic       fend_r;
  logic       load;
  logic       emit;
  logic [7:0] byte_sel;
  logic       hi_flag, lo_flag;

  assign load = !valid_r || out_tready;
  assign emit = load && !q_empty;
  assign q_pop = emit && (nxt == P_DONE);

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;
  assign out_tuser  = fend_r;

  // current byte and the next applicable phase of the head descriptor
  always_comb begin
    hi_flag = (q_data.crc[15:8] == FLAG_BYTE);
    lo_flag = (q_data.crc[7:0] == FLAG_BYTE);
    cur = phase_r;
    if (phase_r == P_NEW) cur = q_data.start ? P_START : P_BODY;
    byte_sel = STUFF_BYTE;
    nxt      = P_DONE;
    case (cur)
      P_START: begin
        byte_sel = FLAG_BYTE;
        nxt      = P_BODY;
      end
      P_BODY: begin
        byte_sel = q_data.body;
        nxt      = q_data.stuff ? P_BSTUFF : (q_data.last ? P_CRCH : P_DONE);
      end
      P_BSTUFF: begin
        byte_sel = STUFF_BYTE;
        nxt      = q_data.last ? P_CRCH : P_DONE;
      end
      P_CRCH: begin
        byte_sel = q_data.crc[15:8];
        nxt      = hi_flag ? P_CRCHS : P_CRCL;
      end
      P_CRCHS: begin
        byte_sel = STUFF_BYTE;
        nxt      = P_CRCL;
      end
      P_CRCL: begin
        byte_sel = q_data.crc[7:0];
        nxt      = lo_flag ? P_CRCLS : P_FLAG;
      end
      P_CRCLS: begin
        byte_sel = STUFF_BYTE;
        nxt      = P_FLAG;
      end
      P_FLAG: begin
        byte_sel = FLAG_BYTE;
        nxt      = P_CR;
      end
      P_CR: begin
        byte_sel = CR_BYTE;
        nxt      = P_DONE;
      end
      default: begin
        byte_sel = STUFF_BYTE;
        nxt      = P_DONE;
      end
    endcase
    phase_nxt = phase_r;
    if (emit) phase_nxt = (nxt == P_DONE) ? P_NEW : nxt;
  end

  // phase and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_NEW;
      valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (load) valid_r <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      data_r <= byte_sel;
      last_r <= (nxt == P_DONE);
      fend_r <= (cur == P_CR);
    end
  end

endmodule
